>>> hw/rtl/chord_tap_hold_decoder_macros.svh
// assertion macros for the chord decoder
// used by the top level; expects clk and rst_n in scope
`ifndef CHORD_TAP_HOLD_DECODER_MACROS_SVH
`define CHORD_TAP_HOLD_DECODER_MACROS_SVH

// checked only outside reset
`define CTHD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked through reset as well
`define CTHD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/cthd_pkg.sv
// shared types, constants and key match function for the chord decoder
// no dependencies
package cthd_pkg;

    localparam int ADDR_W        = 4;
    localparam int DATA_W        = 32;
    localparam int RES_DEPTH_DEF = 4;

    localparam logic [7:0] KEY_ALT_GENERIC   = 8'd18;
    localparam logic [7:0] KEY_ALT_LEFT      = 8'd164;
    localparam logic [7:0] KEY_ALT_RIGHT     = 8'd165;
    localparam logic [7:0] KEY_SHIFT_GENERIC = 8'd16;
    localparam logic [7:0] KEY_SHIFT_LEFT    = 8'd160;
    localparam logic [7:0] KEY_SHIFT_RIGHT   = 8'd161;

    localparam logic [7:0]  INIT_KEY_RST    = 8'd18;
    localparam logic [7:0]  MOD_KEY_RST     = 8'd16;
    localparam logic [15:0] TAP_TO_RST      = 16'd300;
    localparam logic [15:0] OVERLAY_TO_RST  = 16'd500;

    localparam logic [7:0] TAP_MAX = 8'd255;

    typedef enum logic [1:0] {
        KIND_DOWN  = 2'd0,
        KIND_UP    = 2'd1,
        KIND_OTHER = 2'd2,
        KIND_RSVD  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ACT_TAP    = 3'd0,
        ACT_HOLD   = 3'd1,
        ACT_CYCLE  = 3'd2,
        ACT_CANCEL = 3'd3,
        ACT_COMMIT = 3'd4,
        ACT_SELECT = 3'd5
    } action_t;

    typedef struct packed {
        logic [7:0]  initiator_key;
        logic [7:0]  modifier_key;
        logic [15:0] tap_timeout_ms;
        logic [15:0] overlay_timeout_ms;
    } cfg_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] select_index;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } push_t;

    // generic alt and shift codes stand for both sides only
    function automatic logic key_matches(logic [7:0] code, logic [7:0] want);
        logic hit;
        if (want == KEY_ALT_GENERIC)
            hit = (code == KEY_ALT_LEFT) || (code == KEY_ALT_RIGHT);
        else if (want == KEY_SHIFT_GENERIC)
            hit = (code == KEY_SHIFT_LEFT) || (code == KEY_SHIFT_RIGHT);
        else
            hit = (code == want);
        return hit;
    endfunction

endpackage

>>> hw/rtl/cthd_ifs.sv
// valid/ready channel interfaces for key events and decoded results
// no dependencies
interface cthd_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  key_code;
    logic [31:0] timestamp_ms;

    modport source (output valid, kind, key_code, timestamp_ms, input ready);
    modport sink   (input valid, kind, key_code, timestamp_ms, output ready);
endinterface

interface cthd_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] select_index;
    logic       last;

    modport source (output valid, action, select_index, last, input ready);
    modport sink   (input valid, action, select_index, last, output ready);
endinterface

>>> hw/rtl/cthd_regs.sv
// apb configuration registers of the chord decoder
// depends on cthd_pkg
module cthd_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cthd_pkg::ADDR_W-1:0] paddr,
    input  logic [cthd_pkg::DATA_W-1:0] pwdata,
    output logic [cthd_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output cthd_pkg::cfg_t             cfg
);
    import cthd_pkg::*;

    localparam logic [1:0] REG_INIT    = 2'd0;
    localparam logic [1:0] REG_MOD     = 2'd1;
    localparam logic [1:0] REG_TAP_TO  = 2'd2;
    localparam logic [1:0] REG_OVL_TO  = 2'd3;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initiator_key      <= INIT_KEY_RST;
            cfg_reg.modifier_key       <= MOD_KEY_RST;
            cfg_reg.tap_timeout_ms     <= TAP_TO_RST;
            cfg_reg.overlay_timeout_ms <= OVERLAY_TO_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_INIT:   cfg_reg.initiator_key      <= pwdata[7:0];
                REG_MOD:    cfg_reg.modifier_key       <= pwdata[7:0];
                REG_TAP_TO: cfg_reg.tap_timeout_ms     <= pwdata[15:0];
                REG_OVL_TO: cfg_reg.overlay_timeout_ms <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_INIT:   prdata = {24'd0, cfg_reg.initiator_key};
            REG_MOD:    prdata = {24'd0, cfg_reg.modifier_key};
            REG_TAP_TO: prdata = {16'd0, cfg_reg.tap_timeout_ms};
            REG_OVL_TO: prdata = {16'd0, cfg_reg.overlay_timeout_ms};
            default:    prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/cthd_core.sv
// event input register, chord state and decode logic
// depends on cthd_pkg and cthd_ifs; pushes up to two results per event
module cthd_core (
    input  logic            clk,
    input  logic            rst_n,
    input  cthd_pkg::cfg_t  cfg,
    cthd_evt_if.sink        evt,
    input  logic            room2,
    output cthd_pkg::push_t push
);
    import cthd_pkg::*;

    // input register
    logic        stage_valid_reg, stage_valid_next;
    logic [1:0]  kind_reg;
    logic [7:0]  code_reg;
    logic [31:0] ts_reg;

    // chord state
    logic        chord_reg, chord_next;
    logic        hold_reg, hold_next;
    logic [7:0]  tap_reg, tap_next;
    logic [31:0] rel_time_reg, rel_time_next;

    logic        evt_fire, stage_fire;
    logic        down, up, is_init, is_mod;
    logic [31:0] gap;
    logic        hold_force, hold_eff;
    res_t        final_res;

    assign evt.ready  = !stage_valid_reg || room2;
    assign evt_fire   = evt.valid && evt.ready;
    assign stage_fire = stage_valid_reg && room2;

    assign down    = (kind_t'(kind_reg) == KIND_DOWN);
    assign up      = (kind_t'(kind_reg) == KIND_UP);
    assign is_init = key_matches(code_reg, cfg.initiator_key);
    assign is_mod  = key_matches(code_reg, cfg.modifier_key);
    assign gap     = ts_reg - rel_time_reg;

    assign hold_force = !hold_reg && (tap_reg != 8'd0)
                        && (gap > {16'd0, cfg.overlay_timeout_ms});
    assign hold_eff   = hold_reg || hold_force;

    // closing word of a chord
    always_comb
    begin
        final_res = '{action: ACT_CANCEL, select_index: 8'd0, last: 1'b1};
        if (hold_eff)
            final_res.action = ACT_COMMIT;
        else if (tap_reg == 8'd1)
            final_res.action = ACT_TAP;
        else if (tap_reg > 8'd1)
        begin
            final_res.action       = ACT_SELECT;
            final_res.select_index = tap_reg;
        end
    end

    always_comb
    begin
        chord_next    = chord_reg;
        hold_next     = hold_reg;
        tap_next      = tap_reg;
        rel_time_next = rel_time_reg;
        push.n        = 2'd0;
        push.r0       = '{action: ACT_TAP, select_index: 8'd0, last: 1'b1};
        push.r1       = '{action: ACT_TAP, select_index: 8'd0, last: 1'b1};

        if (stage_fire)
        begin
            if (down && !chord_reg && is_init)
            begin
                chord_next = 1'b1;
                hold_next  = 1'b0;
                tap_next   = 8'd0;
            end
            else if (down && chord_reg && is_mod)
            begin
                if (hold_reg)
                begin
                    push.n         = 2'd1;
                    push.r0.action = ACT_CYCLE;
                end
            end
            else if (up && chord_reg && is_mod)
            begin
                rel_time_next = ts_reg;
                if (!hold_reg && tap_reg == 8'd0)
                begin
                    if (gap > {16'd0, cfg.tap_timeout_ms})
                    begin
                        hold_next      = 1'b1;
                        push.n         = 2'd1;
                        push.r0.action = ACT_HOLD;
                    end
                    else
                        tap_next = 8'd1;
                end
                else if (!hold_reg && tap_reg != TAP_MAX)
                    tap_next = tap_reg + 8'd1;
            end
            else if (up && chord_reg && is_init)
            begin
                if (hold_force)
                begin
                    push.n  = 2'd2;
                    push.r0 = '{action: ACT_HOLD, select_index: 8'd0, last: 1'b0};
                    push.r1 = final_res;
                end
                else
                begin
                    push.n  = 2'd1;
                    push.r0 = final_res;
                end
                chord_next = 1'b0;
                hold_next  = 1'b0;
                tap_next   = 8'd0;
            end
        end
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (evt_fire)
            stage_valid_next = 1'b1;
        else if (stage_fire)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            chord_reg       <= 1'b0;
            hold_reg        <= 1'b0;
            tap_reg         <= 8'd0;
            rel_time_reg    <= 32'd0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            chord_reg       <= chord_next;
            hold_reg        <= hold_next;
            tap_reg         <= tap_next;
            rel_time_reg    <= rel_time_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_fire)
        begin
            kind_reg <= evt.kind;
            code_reg <= evt.key_code;
            ts_reg   <= evt.timestamp_ms;
        end
    end

endmodule

>>> hw/rtl/cthd_out_fifo.sv
// result queue: takes up to two words per cycle, hands out one
// depends on cthd_pkg and cthd_ifs
module cthd_out_fifo #(
    parameter int DEPTH = cthd_pkg::RES_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cthd_pkg::push_t push,
    output logic            room2,
    cthd_res_if.source      res
);
    import cthd_pkg::*;

    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    res_t             entry_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    res_t             head;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(DEPTH - 1))
            q = '0;
        else
            q = p + PTR_W'(1);
        return q;
    endfunction

    assign head             = entry_mem[rd_ptr_reg];
    assign res.valid        = (count_reg != '0);
    assign res.action       = head.action;
    assign res.select_index = head.select_index;
    assign res.last         = head.last;
    assign pop              = res.valid && res.ready;
    assign room2            = (count_reg <= CNT_W'(DEPTH - 2));

    assign wr_ptr_inc  = ptr_inc(wr_ptr_reg);
    assign wr_ptr_next = (push.n == 2'd2) ? ptr_inc(wr_ptr_inc)
                       : (push.n == 2'd1) ? wr_ptr_inc : wr_ptr_reg;
    assign rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
    assign count_next  = count_reg + CNT_W'(push.n) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            entry_mem[wr_ptr_reg] <= push.r0;
        if (push.n == 2'd2)
            entry_mem[wr_ptr_inc] <= push.r1;
    end

endmodule

>>> hw/rtl/chord_tap_hold_decoder.sv
// chord decoder top: one event word accepted per cycle while the input is not stalled; the first
// result word passes through the event input register and the result queue before it is offered.
// an event that closes a chord after a late gap yields two words, pushed into the queue together;
// input stalls only while the queue lacks room for two words behind a held event.
// rst_n (async, low) clears chord state and queue pointers and resets config registers to defaults.
// depends on cthd_pkg, cthd_ifs, cthd_regs, cthd_core, cthd_out_fifo
`include "chord_tap_hold_decoder_macros.svh"

module chord_tap_hold_decoder #(
    parameter int RES_DEPTH = cthd_pkg::RES_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cthd_pkg::ADDR_W-1:0] paddr,
    input  logic [cthd_pkg::DATA_W-1:0] pwdata,
    output logic [cthd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    cthd_evt_if.sink                    evt,
    cthd_res_if.source                  res
);
    import cthd_pkg::*;

    cfg_t  cfg;
    push_t push;
    logic  room2;
    logic  late_pair_ok;

    cthd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cthd_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .evt   (evt),
        .room2 (room2),
        .push  (push)
    );

    cthd_out_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room2 (room2),
        .res   (res)
    );

    assign late_pair_ok = (push.r0.action == ACT_HOLD) && (push.r1.action == ACT_COMMIT)
                          && push.r1.last;

    // a word that is not final has its partner queued right behind it
    `CTHD_ASSERT(a_partner_follows, res.valid && !res.last |=> res.valid, "missing final word")
    // a double push is always a late hold followed by commit
    `CTHD_ASSERT(a_double_push, push.n == 2'd2 |-> late_pair_ok, "bad word pair")
    // queue comes out of reset empty
    `CTHD_ASSERT_ALWAYS(a_reset_empty, $rose(rst_n) |-> !res.valid, "queue not empty after reset")

endmodule

>>> test/chord_tap_hold_decoder_tb.sv
// self-checking testbench for chord_tap_hold_decoder: a table of directed key events, then
// random chords over several register settings, checked word by word against a local predictor
// depends on cthd_pkg, cthd_ifs and the chord_tap_hold_decoder rtl
module chord_tap_hold_decoder_tb;
    import cthd_pkg::*;

    typedef enum logic [3:0] {
        REG_INIT = 4'd0,
        REG_MOD  = 4'd4,
        REG_TAP  = 4'd8,
        REG_OVL  = 4'd12
    } reg_addr_t;

    // one key event; n >= 0 means the expected words are typed in a0/a1/idx
    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  code;
        logic [31:0] ts;
        int          n;
        action_t     a0;
        action_t     a1;
        logic [7:0]  idx;
    } step_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    cthd_evt_if evt_ch ();
    cthd_res_if res_ch ();

    chord_tap_hold_decoder u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .evt     (evt_ch),
        .res     (res_ch)
    );

    // register copies
    logic [7:0]  cfg_init = INIT_KEY_RST;
    logic [7:0]  cfg_mod  = MOD_KEY_RST;
    logic [15:0] cfg_tap  = TAP_TO_RST;
    logic [15:0] cfg_ovl  = OVERLAY_TO_RST;

    // chord state copies
    logic        chord_on = 1'b0;
    logic        hold_on  = 1'b0;
    logic [7:0]  taps     = 8'd0;
    logic [31:0] rel_ms   = 32'd0;

    res_t        pending_words[$];
    int          fail_count   = 0;
    int          items_sent   = 0;
    logic [31:0] clock_ms     = 32'd0;
    bit          steady       = 1'b0;
    bit          hold_off_req = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("chord_tap_hold_decoder_tb: done, errors");
        $finish;
    end

    function automatic res_t word_of(action_t a, logic [7:0] idx, logic last);
        res_t w;
        w.action       = a;
        w.select_index = idx;
        w.last         = last;
        return w;
    endfunction

    function automatic logic code_hits(logic [7:0] code, logic [7:0] want);
        if (want == KEY_ALT_GENERIC)
            return code == KEY_ALT_LEFT || code == KEY_ALT_RIGHT;
        if (want == KEY_SHIFT_GENERIC)
            return code == KEY_SHIFT_LEFT || code == KEY_SHIFT_RIGHT;
        return code == want;
    endfunction

    function automatic logic [7:0] pick_code(logic [7:0] want);
        if (want == KEY_ALT_GENERIC)
            return $urandom_range(0, 1) ? KEY_ALT_RIGHT : KEY_ALT_LEFT;
        if (want == KEY_SHIFT_GENERIC)
            return $urandom_range(0, 1) ? KEY_SHIFT_RIGHT : KEY_SHIFT_LEFT;
        return want;
    endfunction

    // advances the chord state by one event and returns the words it emits
    function automatic int decode_event(logic [1:0] kind, logic [7:0] code, logic [31:0] ts,
                                        output res_t r0, output res_t r1);
        logic        press;
        logic        lift;
        logic        hit_init;
        logic        hit_mod;
        logic [31:0] gap;
        res_t        outs[2];
        int          n;
        press    = kind == KIND_DOWN;
        lift     = kind == KIND_UP;
        hit_init = code_hits(code, cfg_init);
        hit_mod  = code_hits(code, cfg_mod);
        n        = 0;
        outs[0]  = word_of(ACT_TAP, 8'd0, 1'b0);
        outs[1]  = outs[0];
        if (press && !chord_on && hit_init)
        begin
            chord_on = 1'b1;
            hold_on  = 1'b0;
            taps     = 8'd0;
        end
        else if (press && chord_on && hit_mod)
        begin
            if (hold_on)
            begin
                outs[n] = word_of(ACT_CYCLE, 8'd0, 1'b0);
                n++;
            end
        end
        else if (lift && chord_on && hit_mod)
        begin
            gap    = ts - rel_ms;
            rel_ms = ts;
            if (!hold_on && taps == 8'd0)
            begin
                if (gap > {16'd0, cfg_tap})
                begin
                    hold_on = 1'b1;
                    outs[n] = word_of(ACT_HOLD, 8'd0, 1'b0);
                    n++;
                end
                else
                    taps = 8'd1;
            end
            else if (!hold_on && taps != TAP_MAX)
                taps = taps + 8'd1;
        end
        else if (lift && chord_on && hit_init)
        begin
            gap = ts - rel_ms;
            // taps followed by a long pause turn into a late hold
            if (!hold_on && taps != 8'd0 && gap > {16'd0, cfg_ovl})
            begin
                hold_on = 1'b1;
                outs[n] = word_of(ACT_HOLD, 8'd0, 1'b0);
                n++;
            end
            if (hold_on)
                outs[n] = word_of(ACT_COMMIT, 8'd0, 1'b0);
            else if (taps == 8'd1)
                outs[n] = word_of(ACT_TAP, 8'd0, 1'b0);
            else if (taps > 8'd1)
                outs[n] = word_of(ACT_SELECT, taps, 1'b0);
            else
                outs[n] = word_of(ACT_CANCEL, 8'd0, 1'b0);
            n++;
            chord_on = 1'b0;
            hold_on  = 1'b0;
            taps     = 8'd0;
        end
        if (n > 0)
            outs[n-1].last = 1'b1;
        r0 = outs[0];
        r1 = outs[1];
        return n;
    endfunction

    function automatic step_t ev(logic [1:0] kind, logic [7:0] code, logic [31:0] ts);
        step_t s;
        s.kind = kind;
        s.code = code;
        s.ts   = ts;
        s.n    = -1;
        s.a0   = ACT_TAP;
        s.a1   = ACT_TAP;
        s.idx  = 8'd0;
        return s;
    endfunction

    function automatic logic [31:0] pick_gap();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 50);
            1:       return {16'd0, cfg_tap} + $urandom_range(0, 4) - 2;
            2:       return {16'd0, cfg_ovl} + $urandom_range(0, 4) - 2;
            3:       return $urandom_range(0, 1000);
            4:       return $urandom_range(0, 70000);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_event(input step_t s);
        res_t p0;
        res_t p1;
        int   n;
        while (!steady && $urandom_range(0, 99) < 24)
        begin
            evt_ch.valid <= 1'b0;
            @(posedge clk);
        end
        evt_ch.valid        <= 1'b1;
        evt_ch.kind         <= s.kind;
        evt_ch.key_code     <= s.code;
        evt_ch.timestamp_ms <= s.ts;
        @(posedge clk);
        while (!evt_ch.ready)
            @(posedge clk);
        items_sent++;
        n = decode_event(s.kind, s.code, s.ts, p0, p1);
        if (s.n < 0)
        begin
            if (n > 0)
                pending_words.push_back(p0);
            if (n > 1)
                pending_words.push_back(p1);
        end
        else if (s.n == 1)
            pending_words.push_back(word_of(s.a0, s.idx, 1'b1));
        else if (s.n == 2)
        begin
            pending_words.push_back(word_of(s.a0, 8'd0, 1'b0));
            pending_words.push_back(word_of(s.a1, s.idx, 1'b1));
        end
    endtask

    task automatic check_reg(reg_addr_t a, logic [31:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= a;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (prdata !== v)
        begin
            $display("%0t: reg %s read exp %0d got %0d", $time, a.name(), v, prdata);
            fail_count++;
        end
    endtask

    task automatic write_reg(reg_addr_t a, logic [31:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        check_reg(a, v);
    endtask

    task automatic set_config(logic [7:0] i, logic [7:0] m, logic [15:0] t, logic [15:0] o);
        write_reg(REG_INIT, {24'd0, i});
        write_reg(REG_MOD,  {24'd0, m});
        write_reg(REG_TAP,  {16'd0, t});
        write_reg(REG_OVL,  {16'd0, o});
        cfg_init = i;
        cfg_mod  = m;
        cfg_tap  = t;
        cfg_ovl  = o;
    endtask

    // wait for every expected word, then idle on for events that emit none; flag words still missing
    task automatic settle();
        int guard;
        guard = 0;
        while (pending_words.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (12) @(posedge clk);
        if (pending_words.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, pending_words.size());
            fail_count++;
            pending_words.delete();
        end
    endtask

    task automatic send_noise();
        send_event(ev(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), $urandom()));
    endtask

    // mostly well-formed chords with random timing, some noise and unfinished chords
    task automatic run_chords(int count, bit squeeze);
        int stop_at;
        int half;
        int nrel;
        stop_at = items_sent + count;
        half    = items_sent + count / 2;
        while (items_sent < stop_at)
        begin
            if (squeeze && items_sent >= half)
            begin
                hold_off_req = 1'b1;
                squeeze      = 1'b0;
            end
            if ($urandom_range(0, 99) < 15)
                send_noise();
            else
            begin
                send_event(ev(KIND_DOWN, pick_code(cfg_init), clock_ms));
                nrel = $urandom_range(0, 5);
                repeat (nrel)
                begin
                    if ($urandom_range(0, 99) < 50)
                        send_event(ev(KIND_DOWN, pick_code(cfg_mod), clock_ms));
                    if ($urandom_range(0, 99) < 5)
                        send_event(ev(KIND_DOWN, pick_code(cfg_init), clock_ms));
                    if ($urandom_range(0, 99) < 10)
                        send_noise();
                    clock_ms += pick_gap();
                    send_event(ev(KIND_UP, pick_code(cfg_mod), clock_ms));
                end
                if ($urandom_range(0, 99) < 40)
                    send_event(ev(KIND_DOWN, pick_code(cfg_mod), clock_ms));
                if ($urandom_range(0, 99) >= 8)
                begin
                    clock_ms += pick_gap();
                    send_event(ev(KIND_UP, pick_code(cfg_init), clock_ms));
                end
            end
        end
        evt_ch.valid <= 1'b0;
        settle();
    endtask

    initial
    begin : receiver
        int wait_left;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                res_ch.ready <= 1'b0;
                for (wait_left = 80; wait_left > 0; wait_left--)
                    @(posedge clk);
            end
            res_ch.ready <= steady || ($urandom_range(0, 99) >= 24);
        end
    end

    always @(posedge clk)
    begin : word_check
        res_t w;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word exp none got action %0d index %0d last %0d",
                         $time, res_ch.action, res_ch.select_index, res_ch.last);
                fail_count++;
            end
            else
            begin
                w = pending_words.pop_front();
                if (res_ch.action !== w.action)
                begin
                    $display("%0t: action exp %0d got %0d", $time, w.action, res_ch.action);
                    fail_count++;
                end
                if (res_ch.select_index !== w.select_index)
                begin
                    $display("%0t: select_index exp %0d got %0d", $time, w.select_index,
                             res_ch.select_index);
                    fail_count++;
                end
                if (res_ch.last !== w.last)
                begin
                    $display("%0t: last exp %0d got %0d", $time, w.last, res_ch.last);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        step_t plan [27];
        step_t s;
        plan = '{
            '{KIND_OTHER, KEY_ALT_LEFT,    32'd0,    0, ACT_TAP,    ACT_TAP,    8'd0},
            '{KIND_RSVD,  KEY_ALT_RIGHT,   32'd0,    0, ACT_TAP,    ACT_TAP,    8'd0},
            '{KIND_UP,    KEY_ALT_LEFT,    32'd0,    0, ACT_TAP,    ACT_TAP,    8'd0},
            // the generic code itself never matches
            '{KIND_DOWN,  KEY_ALT_GENERIC, 32'd100,  0, ACT_TAP,    ACT_TAP,    8'd0},
            '{KIND_DOWN,  KEY_ALT_LEFT,    32'd1000, 0, ACT_TAP,    ACT_TAP,    8'd0},
            '{KIND_DOWN,  KEY_ALT_RIGHT,   32'd1005, 0, ACT_TAP,    ACT_TAP,    8'd0},
            '{KIND_UP,    KEY_ALT_RIGHT,   32'd1010, 1, ACT_CANCEL, ACT_TAP,    8'd0},
            '{KIND_DOWN,  KEY_ALT_RIGHT,   32'd2000, 0, ACT_TAP,    ACT_TAP,    8'd0},
            '{KIND_DOWN,  KEY_SHIFT_LEFT,  32'd2050, 0, ACT_TAP,    ACT_TAP,    8'd0},
            '{KIND_UP,    KEY_SHIFT_LEFT,  32'd2100, 1, ACT_HOLD,   ACT_TAP,    8'd0},
            '{KIND_DOWN,  KEY_SHIFT_RIGHT, 32'd2200, 1, ACT_CYCLE,  ACT_TAP,    8'd0},
            '{KIND_UP,    KEY_SHIFT_RIGHT, 32'd2300, 0, ACT_TAP,    ACT_TAP,    8'd0},
            '{KIND_UP,    KEY_ALT_LEFT,    32'd2400, 1, ACT_COMMIT, ACT_TAP,    8'd0},
            // gaps equal to the timeouts still count as taps
            '{KIND_DOWN,  KEY_ALT_LEFT,    32'd3000, 0, ACT_TAP,    ACT_TAP,    8'd0},
            '{KIND_UP,    KEY_SHIFT_LEFT,  32'd2600, 0, ACT_TAP,    ACT_TAP,    8'd0},
            '{KIND_UP,    KEY_ALT_LEFT,    32'd3100, 1, ACT_TAP,    ACT_TAP,    8'd0},
            '{KIND_DOWN,  KEY_ALT_LEFT,    32'd3200, 0, ACT_TAP,    ACT_TAP,    8'd0},
            '{KIND_UP,    KEY_SHIFT_LEFT,  32'd2650, 0, ACT_TAP,    ACT_TAP,    8'd0},
            '{KIND_UP,    KEY_SHIFT_RIGHT, 32'd2700, 0, ACT_TAP,    ACT_TAP,    8'd0},
            '{KIND_UP,    KEY_SHIFT_LEFT,  32'd2750, 0, ACT_TAP,    ACT_TAP,    8'd0},
            '{KIND_UP,    KEY_ALT_RIGHT,   32'd3000, 1, ACT_SELECT, ACT_TAP,    8'd3},
            '{KIND_DOWN,  KEY_ALT_LEFT,    32'd0,    0, ACT_TAP,    ACT_TAP,    8'd0},
            '{KIND_UP,    KEY_SHIFT_RIGHT, '1,       1, ACT_HOLD,   ACT_TAP,    8'd0},
            '{KIND_UP,    KEY_ALT_RIGHT,   32'h10,   1, ACT_COMMIT, ACT_TAP,    8'd0},
            // release gap across the 32-bit wrap, then a late hold
            '{KIND_DOWN,  KEY_ALT_LEFT,    32'd5,    0, ACT_TAP,    ACT_TAP,    8'd0},
            '{KIND_UP,    KEY_SHIFT_LEFT,  32'h20,   0, ACT_TAP,    ACT_TAP,    8'd0},
            '{KIND_UP,    KEY_ALT_LEFT,    32'h215,  2, ACT_HOLD,   ACT_COMMIT, 8'd0}
        };
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= REG_INIT;
        pwdata              <= '0;
        evt_ch.valid        <= 1'b0;
        evt_ch.kind         <= KIND_OTHER;
        evt_ch.key_code     <= 8'd0;
        evt_ch.timestamp_ms <= 32'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_reg(REG_INIT, {24'd0, INIT_KEY_RST});
        check_reg(REG_MOD,  {24'd0, MOD_KEY_RST});
        check_reg(REG_TAP,  {16'd0, TAP_TO_RST});
        check_reg(REG_OVL,  {16'd0, OVERLAY_TO_RST});

        foreach (plan[i])
            send_event(plan[i]);
        evt_ch.valid <= 1'b0;
        settle();

        // zero timeouts: almost every release is a hold, so words pile up
        set_config(KEY_ALT_GENERIC, KEY_SHIFT_GENERIC, 16'd0, 16'd0);
        run_chords(250, 1'b1);

        // swapped generic keys, widest timeouts, one chord that saturates the tap count
        set_config(KEY_SHIFT_GENERIC, KEY_ALT_GENERIC, 16'hFFFF, 16'hFFFF);
        if (chord_on)
            send_event(ev(KIND_UP, pick_code(cfg_init), clock_ms));
        clock_ms = rel_ms;
        send_event(ev(KIND_DOWN, pick_code(cfg_init), clock_ms));
        repeat (260)
        begin
            clock_ms += $urandom_range(0, 200);
            send_event(ev(KIND_UP, pick_code(cfg_mod), clock_ms));
        end
        clock_ms += $urandom_range(0, 200);
        s     = ev(KIND_UP, pick_code(cfg_init), clock_ms);
        s.n   = 1;
        s.a0  = ACT_SELECT;
        s.idx = TAP_MAX;
        send_event(s);
        run_chords(120, 1'b1);

        // extreme key codes with no idling on either side
        steady = 1'b1;
        set_config(8'd0, 8'd255, 16'($urandom_range(0, 1000)), 16'($urandom_range(0, 1000)));
        run_chords(250, 1'b0);
        steady = 1'b0;

        set_config(8'd255, 8'd0, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        run_chords(250, 1'b1);

        // initiator also matches the modifier, so an open chord never closes here
        set_config(KEY_ALT_LEFT, KEY_ALT_GENERIC, 16'($urandom_range(0, 600)),
                   16'($urandom_range(0, 600)));
        run_chords(250, 1'b0);

        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        run_chords(250, 1'b1);

        set_config(INIT_KEY_RST, MOD_KEY_RST, TAP_TO_RST, OVERLAY_TO_RST);
        run_chords(40, 1'b0);

        if (fail_count == 0)
            $display("chord_tap_hold_decoder_tb: done, clean");
        else
            $display("chord_tap_hold_decoder_tb: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/cthd_pkg.sv
hw/rtl/cthd_ifs.sv
hw/rtl/cthd_regs.sv
hw/rtl/cthd_core.sv
hw/rtl/cthd_out_fifo.sv
hw/rtl/chord_tap_hold_decoder.sv
test/chord_tap_hold_decoder_tb.sv
